>>> rtl/core/wxts_pkg.sv
// Shared types, constants and lookup functions for the waypoint cross-track steering block.
// No dependencies; used by every module in rtl/core.
package wxts_pkg;

  localparam int unsigned CordicIterDefault = 16;
  localparam int unsigned LenW  = 34;   // floor sqrt of a 65-bit sum of squares
  localparam int unsigned QuotW = 33;   // quotient bits kept, saturated above
  localparam int unsigned NumW  = 66;   // magnitude of a dot or cross product sum
  localparam int unsigned AngW  = 36;   // CORDIC angle and vector width
  localparam logic signed [AngW-1:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [31:0] Rad2DegQ24 = 32'sd961263669;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_OTHER = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_ARRIVED = 2'd2,
    ST_RESET   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_START_X      = 3'd0,
    CFG_START_Y      = 3'd1,
    CFG_TARGET_X     = 3'd2,
    CFG_TARGET_Y     = 3'd3,
    CFG_XTE_GAIN     = 3'd4,
    CFG_ARRIVE_DIST  = 3'd5,
    CFG_CRUISE_SPEED = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LEG_IDLE,
    LEG_MUL,
    LEG_SUM,
    LEG_RUN
  } leg_state_e;

  // Leg geometry handed from the leg solver to the sample pipeline.
  typedef struct packed {
    logic            busy;
    logic            len_zero;
    logic [LenW-1:0] len;
    logic [31:0]     head;
  } leg_status_t;

  // atan(2^-i) in Q2.30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    case (i)
      5'd0:  r = 31'd843314857;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043837;
      5'd3:  r = 31'd133525159;
      5'd4:  r = 31'd67021687;
      5'd5:  r = 31'd33543516;
      5'd6:  r = 31'd16775851;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194283;
      5'd9:  r = 31'd2097149;
      5'd31: r = 31'd0;
      default: r = 31'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/wxts_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on wxts_pkg for widths.
module wxts_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [wxts_pkg::NumW-1:0]    num_i,
  input  logic [wxts_pkg::LenW-1:0]    len_i,
  output logic [wxts_pkg::QuotW-1:0]   quot_o
);

  localparam int unsigned QW = wxts_pkg::QuotW;
  localparam int unsigned LW = wxts_pkg::LenW;

  logic [LW-1:0] rem_in [QW];
  logic [QW-1:0] low_in [QW];
  logic [QW-1:0] q_in   [QW];
  logic          ovf_in [QW];
  logic [LW-1:0] rem_q  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [QW-1:0] q_q    [QW];
  logic          ovf_q  [QW];

  // Dividend above the quotient range must stay below the divisor.
  assign rem_in[0] = {1'b0, num_i[wxts_pkg::NumW-1:QW]};
  assign low_in[0] = num_i[QW-1:0];
  assign q_in[0]   = '0;
  assign ovf_in[0] = ({1'b0, num_i[wxts_pkg::NumW-1:QW]} >= len_i);

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LW:0]   trial;
    logic          ge;

    if (k > 0) begin : g_link
      assign rem_in[k] = rem_q[k-1];
      assign low_in[k] = low_q[k-1];
      assign q_in[k]   = q_q[k-1];
      assign ovf_in[k] = ovf_q[k-1];
    end

    assign trial = {rem_in[k], low_in[k][QW-1]};
    assign ge    = (trial >= {1'b0, len_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? LW'(trial - {1'b0, len_i}) : trial[LW-1:0];
        low_q[k] <= {low_in[k][QW-2:0], 1'b0};
        q_q[k]   <= {q_in[k][QW-2:0], ge};
        ovf_q[k] <= ovf_in[k];
      end
    end
  end

  assign quot_o = ovf_q[QW-1] ? '1 : q_q[QW-1];

endmodule

>>> rtl/core/wxts_leg.sv
// Leg solver: length (digit-by-digit square root) and heading (CORDIC) of the leg.
// Depends on wxts_pkg; runs once after each write of a leg endpoint.
module wxts_leg #(
  parameter int unsigned CORDIC_ITERATIONS = wxts_pkg::CordicIterDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [32:0]        ax_i,
  input  logic signed [32:0]        ay_i,
  output wxts_pkg::leg_status_t     leg_o
);

  localparam int unsigned AW = wxts_pkg::AngW;
  localparam int unsigned LW = wxts_pkg::LenW;
  localparam int unsigned RadW = 2 * LW;
  localparam logic [5:0] LastStep = 6'(LW - 1);
  localparam logic [5:0] CordicN  = 6'(CORDIC_ITERATIONS);

  wxts_pkg::leg_state_e state_q, state_d;

  logic [63:0]         sqx_q, sqy_q;
  logic [RadW-1:0]     rad_q;
  logic [LW+1:0]       rem_q;
  logic [LW-1:0]       root_q;
  logic [5:0]          cnt_q;
  logic signed [AW-1:0] x_q, y_q, z_q;
  logic [LW-1:0]       len_q;
  logic [31:0]         head_q;
  logic                len_zero_q;

  logic [LW+3:0]       rem_t;
  logic [LW+1:0]       sq_trial;
  logic                take;
  logic [LW-1:0]       root_n;
  logic signed [AW-1:0] nx, ny, x0, y0, xs, ys, z_rnd;
  logic signed [AW-1:0] atan_v;

  always_comb begin
    state_d = state_q;
    case (state_q)
      wxts_pkg::LEG_IDLE: if (start_i) state_d = wxts_pkg::LEG_MUL;
      wxts_pkg::LEG_MUL:  state_d = wxts_pkg::LEG_SUM;
      wxts_pkg::LEG_SUM:  state_d = wxts_pkg::LEG_RUN;
      wxts_pkg::LEG_RUN:  if (cnt_q == LastStep) state_d = wxts_pkg::LEG_IDLE;
      default:            state_d = wxts_pkg::LEG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wxts_pkg::LEG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Square root: bring down two radicand bits per step.
  assign rem_t    = {rem_q, rad_q[RadW-1:RadW-2]};
  assign sq_trial = {root_q, 2'b01};
  assign take     = (rem_t >= {2'b00, sq_trial});
  assign root_n   = {root_q[LW-2:0], take};

  // Vector starting point, pre-rotated into the right half plane.
  assign nx = -AW'(ax_i);
  assign ny = -AW'(ay_i);
  assign x0 = nx[AW-1] ? -nx : nx;
  assign y0 = nx[AW-1] ? -ny : ny;

  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign atan_v = AW'(wxts_pkg::atan_q30(cnt_q[4:0]));
  assign z_rnd  = z_q + AW'(8192);

  always_ff @(posedge clk_i) begin
    case (state_q)
      wxts_pkg::LEG_MUL: begin
        sqx_q <= 64'(ax_i * ax_i);
        sqy_q <= 64'(ay_i * ay_i);
        x_q   <= x0;
        y_q   <= y0;
        z_q   <= !nx[AW-1] ? '0 : (ny[AW-1] ? -wxts_pkg::PiQ30 : wxts_pkg::PiQ30);
      end
      wxts_pkg::LEG_SUM: begin
        rad_q  <= RadW'({1'b0, sqx_q} + {1'b0, sqy_q});
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      wxts_pkg::LEG_RUN: begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        rem_q  <= take ? (LW+2)'(rem_t - {2'b00, sq_trial}) : rem_t[LW+1:0];
        root_q <= root_n;
        cnt_q  <= cnt_q + 6'd1;
        if (cnt_q < CordicN) begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_v;
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_v;
          end
        end
      end
      default: ;
    endcase
  end

  // Publish at the last step; a zero-length leg has no heading.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      head_q     <= '0;
      len_zero_q <= 1'b1;
    end else if (state_q == wxts_pkg::LEG_RUN && cnt_q == LastStep) begin
      len_q      <= root_n;
      len_zero_q <= (root_n == '0);
      head_q     <= (root_n == '0) ? '0 : 32'(z_rnd >>> 14);
    end
  end

  assign leg_o.busy     = (state_q != wxts_pkg::LEG_IDLE);
  assign leg_o.len_zero = len_zero_q;
  assign leg_o.len      = len_q;
  assign leg_o.head     = head_q;

endmodule

>>> rtl/core/waypoint_cross_track_steering.sv
// Top level of the waypoint cross-track steering block: config registers, sample pipeline.
// Depends on wxts_pkg, wxts_leg and wxts_div.
//
// Each accepted pose request yields exactly one result request, in order. A new pose is
// taken every cycle while in_stall_o is low; the datapath is one pipeline (4 product
// stages, a 33-stage divider per quotient, 4 steering stages, output register), and the
// whole pipeline holds while a finished result is stalled at the output. Leg length and
// heading depend on configuration only and are solved by a shared sequential unit: after
// a write to a start or target register, in_stall_o and cfg_ready_o stay high and low
// while it passes a product state and a sum state, then 34 square-root steps, the first
// CORDIC_ITERATIONS of which also carry a CORDIC step. Otherwise only a stalled output
// throttles the pose stream. Write configuration only while no result is outstanding.
module waypoint_cross_track_steering #(
  parameter int unsigned CORDIC_ITERATIONS = wxts_pkg::CordicIterDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] current_x_i,
  input  logic [31:0] current_y_i,
  input  logic [1:0]  control_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  move_status_o,
  output logic [30:0] speed_command_o,
  output logic [31:0] target_yaw_rad_o,
  output logic [31:0] target_yaw_deg_o,
  output logic [31:0] cross_track_error_o,
  output logic [31:0] along_distance_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned DivLat = wxts_pkg::QuotW;
  localparam int unsigned NW     = wxts_pkg::NumW;

  // ---------------------------------------------------------------- configuration
  logic [31:0] start_x_q, start_y_q, target_x_q, target_y_q, xte_gain_q;
  logic [30:0] arrive_dist_q, cruise_speed_q;
  logic        cfg_we, leg_start;
  wxts_pkg::leg_status_t leg;

  assign cfg_ready_o = !leg.busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  // Re-solve the leg whenever an endpoint changes.
  assign leg_start   = cfg_we && (cfg_index_i inside {wxts_pkg::CFG_START_X,
                       wxts_pkg::CFG_START_Y, wxts_pkg::CFG_TARGET_X, wxts_pkg::CFG_TARGET_Y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q      <= '0;
      start_y_q      <= '0;
      target_x_q     <= '0;
      target_y_q     <= '0;
      xte_gain_q     <= 32'd13107;
      arrive_dist_q  <= '0;
      cruise_speed_q <= 31'd16384;
    end else if (cfg_we) begin
      case (wxts_pkg::cfg_idx_e'(cfg_index_i))
        wxts_pkg::CFG_START_X:      start_x_q      <= cfg_data_i;
        wxts_pkg::CFG_START_Y:      start_y_q      <= cfg_data_i;
        wxts_pkg::CFG_TARGET_X:     target_x_q     <= cfg_data_i;
        wxts_pkg::CFG_TARGET_Y:     target_y_q     <= cfg_data_i;
        wxts_pkg::CFG_XTE_GAIN:     xte_gain_q     <= cfg_data_i;
        wxts_pkg::CFG_ARRIVE_DIST:  arrive_dist_q  <= cfg_data_i[30:0];
        wxts_pkg::CFG_CRUISE_SPEED: cruise_speed_q <= cfg_data_i[30:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Leg vector A = start - target, exact in 33 bits.
  logic signed [32:0] ax, ay;
  assign ax = $signed({start_x_q[31], start_x_q}) - $signed({target_x_q[31], target_x_q});
  assign ay = $signed({start_y_q[31], start_y_q}) - $signed({target_y_q[31], target_y_q});

  wxts_leg #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_leg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(leg_start),
    .ax_i   (ax),
    .ay_i   (ay),
    .leg_o  (leg)
  );

  // ---------------------------------------------------------------- flow control
  // The pipeline moves as a whole unless the output register holds a stalled result.
  logic adv, accept;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv || leg.busy;
  assign accept     = in_valid_i && !in_stall_o;

  // Stage 0: pose relative to target.
  logic               v0_q;
  logic signed [32:0] bx0_q, by0_q;
  logic [1:0]         mode0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= accept;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bx0_q   <= $signed({current_x_i[31], current_x_i}) -
                 $signed({target_x_q[31], target_x_q});
      by0_q   <= $signed({current_y_i[31], current_y_i}) -
                 $signed({target_y_q[31], target_y_q});
      mode0_q <= control_mode_i;
    end
  end

  // Stage 1: four products.
  logic               v1_q;
  logic signed [65:0] pdx1_q, pdy1_q, pcx1_q, pcy1_q;
  logic [1:0]         mode1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pdx1_q  <= ax * bx0_q;
      pdy1_q  <= ay * by0_q;
      pcx1_q  <= ax * by0_q;
      pcy1_q  <= ay * bx0_q;
      mode1_q <= mode0_q;
    end
  end

  // Stage 2: dot and cross sums.
  logic               v2_q;
  logic signed [66:0] dot2_q, crs2_q;
  logic [1:0]         mode2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot2_q  <= 67'(pdx1_q) + 67'(pdy1_q);
      crs2_q  <= 67'(pcx1_q) - 67'(pcy1_q);
      mode2_q <= mode1_q;
    end
  end

  // Stage 3: sign and magnitude for the dividers.
  logic          v3_q, dneg3_q, cneg3_q;
  logic [NW-1:0] dmag3_q, cmag3_q;
  logic [1:0]    mode3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dneg3_q <= dot2_q[66];
      cneg3_q <= crs2_q[66];
      dmag3_q <= NW'(dot2_q[66] ? -dot2_q : dot2_q);
      cmag3_q <= NW'(crs2_q[66] ? -crs2_q : crs2_q);
      mode3_q <= mode2_q;
    end
  end

  // Dividers by the leg length.
  logic [wxts_pkg::QuotW-1:0] dq, cq;

  wxts_div u_div_along (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (dmag3_q),
    .len_i (leg.len),
    .quot_o(dq)
  );

  wxts_div u_div_cross (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (cmag3_q),
    .len_i (leg.len),
    .quot_o(cq)
  );

  // Side line alongside the dividers.
  logic       sb_v_q    [DivLat];
  logic       sb_dneg_q [DivLat];
  logic       sb_cneg_q [DivLat];
  logic [1:0] sb_mode_q [DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) sb_v_q[i] <= 1'b0;
    end else if (adv) begin
      sb_v_q[0] <= v3_q;
      for (int i = 1; i < DivLat; i++) sb_v_q[i] <= sb_v_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_dneg_q[0] <= dneg3_q;
      sb_cneg_q[0] <= cneg3_q;
      sb_mode_q[0] <= mode3_q;
      for (int i = 1; i < DivLat; i++) begin
        sb_dneg_q[i] <= sb_dneg_q[i-1];
        sb_cneg_q[i] <= sb_cneg_q[i-1];
        sb_mode_q[i] <= sb_mode_q[i-1];
      end
    end
  end

  function automatic logic [31:0] sat_sm(input logic neg,
                                         input logic [wxts_pkg::QuotW-1:0] mag);
    logic [31:0] r;
    if (neg) r = (mag > 33'h080000000) ? 32'h80000000 : 32'(-mag);
    else     r = (mag > 33'h07fffffff) ? 32'h7fffffff : mag[31:0];
    return r;
  endfunction

  // Stage 5: saturate quotients, decide arrival.
  logic        v5_q, arr5_q;
  logic [31:0] cte5_q, along5_q;
  logic [1:0]  mode5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= sb_v_q[DivLat-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode5_q  <= sb_mode_q[DivLat-1];
      arr5_q   <= leg.len_zero || sb_dneg_q[DivLat-1] ||
                  (dq <= {2'b00, arrive_dist_q});
      cte5_q   <= leg.len_zero ? '0 : sat_sm(sb_cneg_q[DivLat-1], cq);
      along5_q <= leg.len_zero ? '0 : sat_sm(sb_dneg_q[DivLat-1], dq);
    end
  end

  // Stage 6: gain times cross-track error.
  logic               v6_q, arr6_q;
  logic signed [63:0] gprod6_q;
  logic [31:0]        cte6_q, along6_q;
  logic [1:0]         mode6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      gprod6_q <= $signed(xte_gain_q) * $signed(cte5_q);
      arr6_q   <= arr5_q;
      cte6_q   <= cte5_q;
      along6_q <= along5_q;
      mode6_q  <= mode5_q;
    end
  end

  // Stage 7: steering heading.
  logic signed [64:0] gp_rnd;
  logic signed [49:0] yaw_sum;
  logic [31:0]        yaw_sat;

  assign gp_rnd  = 65'(gprod6_q) + 65'sd32768;
  assign yaw_sum = 50'(gp_rnd >>> 16) + 50'($signed(leg.head));
  assign yaw_sat = (yaw_sum > 50'sd2147483647)  ? 32'h7fffffff :
                   (yaw_sum < -50'sd2147483648) ? 32'h80000000 : yaw_sum[31:0];

  logic        v7_q, arr7_q;
  logic [31:0] yaw7_q, cte7_q, along7_q;
  logic [1:0]  mode7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (adv) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      yaw7_q   <= arr6_q ? leg.head : yaw_sat;
      arr7_q   <= arr6_q;
      cte7_q   <= cte6_q;
      along7_q <= along6_q;
      mode7_q  <= mode6_q;
    end
  end

  // Stage 8: scale to degrees.
  logic               v8_q, arr8_q;
  logic signed [63:0] degp8_q;
  logic [31:0]        yaw8_q, cte8_q, along8_q;
  logic [1:0]         mode8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (adv) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      degp8_q  <= $signed(yaw7_q) * wxts_pkg::Rad2DegQ24;
      arr8_q   <= arr7_q;
      yaw8_q   <= yaw7_q;
      cte8_q   <= cte7_q;
      along8_q <= along7_q;
      mode8_q  <= mode7_q;
    end
  end

  // Stage 9: round degrees and form the result; modes other than run give zeros and a stop or reset status.
  logic signed [64:0] dp_rnd;
  logic signed [40:0] deg_full;
  logic [31:0]        deg_sat;

  assign dp_rnd   = 65'(degp8_q) + 65'sd8388608;
  assign deg_full = 41'(dp_rnd >>> 24);
  assign deg_sat  = (deg_full > 41'sd2147483647)  ? 32'h7fffffff :
                    (deg_full < -41'sd2147483648) ? 32'h80000000 : deg_full[31:0];

  logic v9_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else if (adv) v9_q <= v8_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wxts_pkg::mode_e'(mode8_q) == wxts_pkg::MODE_RUN) begin
        move_status_o       <= arr8_q ? wxts_pkg::ST_ARRIVED : wxts_pkg::ST_RUNNING;
        speed_command_o     <= arr8_q ? '0 : cruise_speed_q;
        target_yaw_rad_o    <= yaw8_q;
        target_yaw_deg_o    <= deg_sat;
        cross_track_error_o <= cte8_q;
        along_distance_o    <= along8_q;
      end else begin
        move_status_o       <= (wxts_pkg::mode_e'(mode8_q) == wxts_pkg::MODE_RESET) ?
                               wxts_pkg::ST_RESET : wxts_pkg::ST_STOPPED;
        speed_command_o     <= '0;
        target_yaw_rad_o    <= '0;
        target_yaw_deg_o    <= '0;
        cross_track_error_o <= '0;
        along_distance_o    <= '0;
      end
    end
  end

  assign out_valid_o = v9_q;

`ifndef SYNTHESIS
  // Arrival always commands zero speed.
  a_arrived_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_status_o == wxts_pkg::ST_ARRIVED |-> speed_command_o == '0)
    else $error("arrived result carries nonzero speed");

  // Stopped and reset results carry no heading or speed.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (move_status_o == wxts_pkg::ST_STOPPED ||
                    move_status_o == wxts_pkg::ST_RESET)
    |-> speed_command_o == '0 && target_yaw_rad_o == '0 && target_yaw_deg_o == '0)
    else $error("non-running result is not zeroed");

  // No pose enters while the leg is being re-solved.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(leg_start) |-> !accept)
    else $error("pose accepted during leg solve");
`endif

endmodule

>>> verif/tb_waypoint_cross_track_steering.sv
`timescale 1ns / 1ps
// Self-checking testbench for waypoint_cross_track_steering: pose requests in, steering
// results out, checked against a bit-exact predictor. Depends on wxts_pkg and the RTL.
module tb_waypoint_cross_track_steering;

  // Write to this index must be ignored by the block.
  localparam logic [2:0] CFG_NONE = 3'd7;
  localparam int unsigned TurnSteps = 16;
  localparam longint PiQ30Ref = 64'sd3373259426;
  localparam longint DegPerRadQ24 = 64'sd961263669;

  typedef struct {
    logic [31:0]     x;
    logic [31:0]     y;
    wxts_pkg::mode_e mode;
  } pose_t;

  typedef struct {
    wxts_pkg::status_e status;
    logic [30:0]       speed;
    logic [31:0]       yaw_rad;
    logic [31:0]       yaw_deg;
    logic [31:0]       xte;
    logic [31:0]       along;
  } steer_t;

  // atan(2^-i), Q2.30, for the heading iterations
  longint turn_angle [TurnSteps] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [31:0] current_x = '0;
  logic [31:0] current_y = '0;
  logic [1:0]  control_mode = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [1:0]  move_status_o;
  logic [30:0] speed_command_o;
  logic [31:0] target_yaw_rad_o;
  logic [31:0] target_yaw_deg_o;
  logic [31:0] cross_track_error_o;
  logic [31:0] along_distance_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor's copy of the leg configuration
  logic signed [31:0] leg_sx, leg_sy, leg_tx, leg_ty, leg_gain;
  logic [30:0]        leg_arrive, leg_cruise;

  pose_t  pose_q [$];     // requests waiting for the driver
  steer_t steer_q [$];    // predicted results, oldest first
  pose_t  pose_cur;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int err_cnt = 0;
  int checked_cnt = 0;
  int run_cnt = 0;
  int leg_cnt = 0;

  waypoint_cross_track_steering i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .current_x_i        (current_x),
    .current_y_i        (current_y),
    .control_mode_i     (control_mode),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .move_status_o      (move_status_o),
    .speed_command_o    (speed_command_o),
    .target_yaw_rad_o   (target_yaw_rad_o),
    .target_yaw_deg_o   (target_yaw_deg_o),
    .cross_track_error_o(cross_track_error_o),
    .along_distance_o   (along_distance_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      wxts_pkg::CFG_START_X:      leg_sx = val;
      wxts_pkg::CFG_START_Y:      leg_sy = val;
      wxts_pkg::CFG_TARGET_X:     leg_tx = val;
      wxts_pkg::CFG_TARGET_Y:     leg_ty = val;
      wxts_pkg::CFG_XTE_GAIN:     leg_gain = val;
      wxts_pkg::CFG_ARRIVE_DIST:  leg_arrive = val[30:0];
      wxts_pkg::CFG_CRUISE_SPEED: leg_cruise = val[30:0];
      default: ;
    endcase
  endfunction

  // Steering command for one pose under the current leg
  function automatic steer_t predict_steering(input pose_t p);
    steer_t r;
    longint ax, ay, bx, by, vx, vy, ang, sx, sy, head, xte, yaw, deg;
    logic signed [127:0] sq, dot, crs, len, cand, quot;
    bit arrived;
    r = '{wxts_pkg::ST_STOPPED, '0, '0, '0, '0, '0};
    if (p.mode == wxts_pkg::MODE_RUN) begin
      ax = leg_sx - leg_tx;
      ay = leg_sy - leg_ty;
      bx = $signed(p.x) - leg_tx;
      by = $signed(p.y) - leg_ty;
      sq = ax * ax + ay * ay;
      dot = ax * bx + ay * by;
      crs = ax * by - ay * bx;
      len = 0;
      for (int i = 33; i >= 0; i--) begin
        cand = len | (128'sd1 <<< i);
        if (cand * cand <= sq) len = cand;
      end
      // Leg heading: vector the (target - start) direction down to the x axis
      vx = -ax;
      vy = -ay;
      ang = 0;
      if (vx != 0 || vy != 0) begin
        if (vx < 0) begin
          ang = (vy >= 0) ? PiQ30Ref : -PiQ30Ref;
          vx = -vx;
          vy = -vy;
        end
        for (int i = 0; i < TurnSteps; i++) begin
          sx = vx >>> i;
          sy = vy >>> i;
          if (vy > 0) begin
            vx += sy; vy -= sx; ang += turn_angle[i];
          end else begin
            vx -= sy; vy += sx; ang -= turn_angle[i];
          end
        end
      end
      head = (ang + 8192) >>> 14;
      xte = 0;
      if (len == 0) begin
        arrived = 1'b1;
        head = 0;
      end else begin
        quot = dot / len;
        r.along = clamp32(quot);
        arrived = (dot < 0) || (quot <= $signed({1'b0, leg_arrive}));
        r.xte = clamp32(crs / len);
        xte = $signed(r.xte);
      end
      if (arrived) begin
        r.status = wxts_pkg::ST_ARRIVED;
        yaw = head;
      end else begin
        r.status = wxts_pkg::ST_RUNNING;
        r.speed = leg_cruise;
        yaw = $signed(clamp32(head + ((longint'(leg_gain) * xte + 32768) >>> 16)));
      end
      r.yaw_rad = yaw[31:0];
      deg = (yaw * DegPerRadQ24 + (64'sd1 <<< 23)) >>> 24;
      r.yaw_deg = clamp32(deg);
    end else if (p.mode == wxts_pkg::MODE_RESET) begin
      r.status = wxts_pkg::ST_RESET;
    end
    return r;
  endfunction

  // Driver: hold the request while stalled, advance on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) steer_q.push_back(predict_steering(pose_cur));
      if (!in_valid || !in_stall_o) begin
        if (pose_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          pose_cur = pose_q.pop_front();
          in_valid <= 1'b1;
          current_x <= pose_cur.x;
          current_y <= pose_cur.y;
          control_mode <= pose_cur.mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction, drive stall
  always @(posedge clk_i or negedge rst_ni) begin
    steer_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (steer_q.size() == 0) begin
          $error("result with no request outstanding");
          err_cnt++;
        end else begin
          e = steer_q.pop_front();
          checked_cnt++;
          if (move_status_o !== e.status) begin
            $error("move_status: expected %0d, got %0d", e.status, move_status_o);
            err_cnt++;
          end
          if (speed_command_o !== e.speed) begin
            $error("speed_command: expected %h, got %h", e.speed, speed_command_o);
            err_cnt++;
          end
          if (target_yaw_rad_o !== e.yaw_rad) begin
            $error("target_yaw_rad: expected %h, got %h", e.yaw_rad, target_yaw_rad_o);
            err_cnt++;
          end
          if (target_yaw_deg_o !== e.yaw_deg) begin
            $error("target_yaw_deg: expected %h, got %h", e.yaw_deg, target_yaw_deg_o);
            err_cnt++;
          end
          if (cross_track_error_o !== e.xte) begin
            $error("cross_track_error: expected %h, got %h", e.xte, cross_track_error_o);
            err_cnt++;
          end
          if (along_distance_o !== e.along) begin
            $error("along_distance: expected %h, got %h", e.along, along_distance_o);
            err_cnt++;
          end
        end
      end
      // A long hold-off, counted here, lets the pipeline fill and back up the input
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_cnt <= 300;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pose_q.size() > 0 || in_valid || steer_q.size() > 0);
  endtask

  // Write one register; the block must be idle
  task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    apply_register(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_leg(input logic [31:0] sx, sy, tx, ty, gain, arrive, cruise);
    wait_drained();
    repeat (50) @(posedge clk_i);
    write_register(wxts_pkg::CFG_START_X, sx);
    write_register(wxts_pkg::CFG_START_Y, sy);
    write_register(wxts_pkg::CFG_TARGET_X, tx);
    write_register(wxts_pkg::CFG_TARGET_Y, ty);
    write_register(wxts_pkg::CFG_XTE_GAIN, gain);
    write_register(wxts_pkg::CFG_ARRIVE_DIST, arrive);
    write_register(wxts_pkg::CFG_CRUISE_SPEED, cruise);
    leg_cnt++;
  endtask

  task automatic push_pose(input logic [31:0] x, y, input wxts_pkg::mode_e m);
    pose_t p;
    p.x = x;
    p.y = y;
    p.mode = m;
    pose_q.push_back(p);
  endtask

  // Mostly run-mode poses spread along and around the leg, some raw noise
  task automatic push_random_poses(input int n);
    longint px, py, span;
    wxts_pkg::mode_e m;
    for (int k = 0; k < n; k++) begin
      m = ($urandom_range(99) < 80) ? wxts_pkg::MODE_RUN :
                                      wxts_pkg::mode_e'($urandom_range(3));
      if ($urandom_range(99) < 15) begin
        push_pose($urandom, $urandom, m);
      end else begin
        span = $urandom_range(0, 20);
        px = leg_tx + ((longint'(leg_sx) - leg_tx) * span) / 16;
        py = leg_ty + ((longint'(leg_sy) - leg_ty) * span) / 16;
        px += $signed(32'($urandom) >>> $urandom_range(8, 31));
        py += $signed(32'($urandom) >>> $urandom_range(8, 31));
        push_pose(clamp32(px), clamp32(py), m);
      end
      if (m == wxts_pkg::MODE_RUN) run_cnt++;
    end
  endtask

  initial begin
    leg_sx = 0; leg_sy = 0; leg_tx = 0; leg_ty = 0;
    leg_gain = 13107; leg_arrive = 0; leg_cruise = 16384;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero-length leg after reset; every mode, extreme positions
    push_pose(32'h8000_0000, 32'h7FFF_FFFF, wxts_pkg::MODE_RUN);
    push_pose(32'h7FFF_FFFF, 32'h8000_0000, wxts_pkg::MODE_RUN);
    push_pose(32'h0, 32'h0, wxts_pkg::MODE_RUN);
    push_pose(32'h1234_5678, 32'hFFFF_FFFF, wxts_pkg::MODE_RESET);
    push_pose(32'hFFFF_FFFF, 32'h1234_5678, wxts_pkg::MODE_STOP);
    push_pose(32'h5555_AAAA, 32'hAAAA_5555, wxts_pkg::MODE_OTHER);

    // Leg along +x, 10 m, arrive within 1 m
    load_leg(0, 0, 10 << 16, 0, 13107, 1 << 16, 16384);
    push_pose(10 << 16, 0, wxts_pkg::MODE_RUN);            // on the target
    push_pose(0, 0, wxts_pkg::MODE_RUN);                   // on the start
    push_pose(9 << 16, 0, wxts_pkg::MODE_RUN);             // exactly at the threshold
    push_pose((9 << 16) - 1, 3 << 16, wxts_pkg::MODE_RUN); // just short of it
    push_pose(12 << 16, 0, wxts_pkg::MODE_RUN);            // past the target
    push_pose(-(5 << 16), -(2 << 16), wxts_pkg::MODE_RUN); // behind the start
    push_pose(32'h7FFF_FFFF, 32'h8000_0000, wxts_pkg::MODE_RUN);
    push_pose(32'h8000_0000, 32'h7FFF_FFFF, wxts_pkg::MODE_RUN);
    push_pose(32'h0, 32'h7FFF_FFFF, wxts_pkg::MODE_RUN);
    push_pose(2 << 16, 1 << 16, wxts_pkg::MODE_STOP);
    push_pose(2 << 16, 1 << 16, wxts_pkg::MODE_RESET);
    push_pose(2 << 16, 1 << 16, wxts_pkg::MODE_OTHER);
    push_random_poses(80);

    // Diagonal leg, sender idling, negative gain, full-scale speed
    load_leg(-(5 << 16), 3 << 16, 20 << 16, -(7 << 16), -40000, 0, 32'h7FFF_FFFF);
    write_register(CFG_NONE, 32'hFFFF_FFFF);
    snd_idle_pct = 78;
    push_random_poses(100);

    // Extreme corners, largest gain and threshold, receiver stalling
    load_leg(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    snd_idle_pct = 0;
    rcv_stall_pct = 78;
    push_random_poses(100);

    // Most negative gain, reversed corners, both sides idling
    load_leg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 1 << 20, 32'h0001_0000);
    snd_idle_pct = 38;
    rcv_stall_pct = 38;
    push_random_poses(100);

    // Short leg; receiver holds off a long time while the sender keeps offering
    load_leg(1 << 16, 1 << 16, 1 << 16, 4 << 16, 65536, 1 << 14, 16384);
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_req = 1'b1;
    push_random_poses(120);

    // Random legs at mixed idling
    for (int ph = 0; ph < 3; ph++) begin
      load_leg($urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(0, 1 << 22), $urandom);
      snd_idle_pct = (ph == 0) ? 78 : 20;
      rcv_stall_pct = (ph == 1) ? 78 : 20;
      push_random_poses(60);
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Checked %0d results (%0d run-mode poses) over %0d leg settings.",
             checked_cnt, run_cnt, leg_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches found", err_cnt);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Timeout waiting for results");
    $display("Verification failed");
    $finish;
  end

endmodule
